>>> hdl/ritoa_pkg.sv
// shared constants and helpers for the radix integer to ascii converter
`default_nettype none

package ritoa_pkg;

  // number format
  localparam int VALUE_WIDTH = 32;           // bits of the converted number
  localparam int VALUE_IN_W  = 32;           // width of the value field on the port
  localparam int BASE_W      = 6;
  localparam int CHAR_W      = 7;
  localparam int COUNT_W     = 6;
  localparam int DIGIT_W     = 6;            // one digit value, 0 to 35

  // digit store and counters
  localparam int DIGIT_DEPTH = VALUE_WIDTH + 1;
  localparam int ADDR_W      = $clog2(DIGIT_DEPTH);
  localparam int CNT_W       = $clog2(VALUE_WIDTH + 2);
  localparam int STEP_W      = $clog2(VALUE_WIDTH);

  // base limits
  localparam logic [BASE_W-1:0] MIN_BASE = BASE_W'(2);
  localparam logic [BASE_W-1:0] MAX_BASE = BASE_W'(36);

  // character codes
  localparam logic [CHAR_W-1:0] ZERO_CODE  = 7'h30;
  localparam logic [CHAR_W-1:0] ALPHA_CODE = 7'h41;
  localparam logic [CHAR_W-1:0] MINUS_CODE = 7'h2D;
  localparam logic [CHAR_W-1:0] NUL_CODE   = 7'h00;
  localparam logic [DIGIT_W-1:0] TEN       = DIGIT_W'(10);

  // digit value to ascii, 0-9 then A-Z
  function automatic logic [CHAR_W-1:0] digit_char(input logic [DIGIT_W-1:0] d);
    logic [CHAR_W-1:0] code;
    if (d < TEN) begin
      code = ZERO_CODE + CHAR_W'(d);
    end else begin
      code = ALPHA_CODE + CHAR_W'(d - TEN);
    end
    return code;
  endfunction

endpackage

`default_nettype wire

>>> hdl/ritoa_if.sv
// input and output channel interfaces of the converter
`default_nettype none

interface ritoa_in_if;
  logic                                 valid;
  logic                                 ready;
  logic [ritoa_pkg::VALUE_IN_W-1:0]     value;
  logic [ritoa_pkg::BASE_W-1:0]         base;
  logic                                 is_signed;

  modport source  (output valid, value, base, is_signed, input ready);
  modport sink    (input valid, value, base, is_signed, output ready);
  modport monitor (input valid, ready, value, base, is_signed);
endinterface

interface ritoa_out_if;
  logic                                 valid;
  logic                                 ready;
  logic [ritoa_pkg::CHAR_W-1:0]         char_code;
  logic                                 last;
  logic [ritoa_pkg::COUNT_W-1:0]        total_chars;
  logic                                 error;

  modport source  (output valid, char_code, last, total_chars, error, input ready);
  modport sink    (input valid, char_code, last, total_chars, error, output ready);
  modport monitor (input valid, ready, char_code, last, total_chars, error);
endinterface

`default_nettype wire

>>> hdl/radix_integer_to_ascii_digits.sv
// top level: integer to ascii digit converter, base 2 to 36
//
// Takes one number per word and emits its characters one word each, most
// significant digit first, with a leading minus for a negative signed number.
// The last word carries last and the character count; a base outside 2 to 36
// gives a single word with error set. Digits are produced least significant
// first by one shared restoring divider (one quotient bit per cycle), kept in
// a small digit ram, and read back in reverse. Each digit takes a start, the
// divider steps and a write-back; each character is then read from the ram,
// loaded and shown, and held until the output takes it.
// The input is ready only while no number is in progress.
`default_nettype none

module radix_integer_to_ascii_digits (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  ritoa_in_if.sink         in_i,
  ritoa_out_if.source      out_o
);

  localparam int VW = ritoa_pkg::VALUE_WIDTH;
  localparam int CW = ritoa_pkg::CNT_W;
  localparam int AW = ritoa_pkg::ADDR_W;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DIV_GO,
    S_DIV_WAIT,
    S_RD,
    S_LOAD,
    S_SHOW
  } state_e;

  state_e                              state_q;
  logic [VW-1:0]                       mag_q;
  logic [ritoa_pkg::BASE_W-1:0]        radix_q;
  logic                                neg_q;
  logic [CW-1:0]                       nd_q;
  logic [CW-1:0]                       idx_q;
  logic [ritoa_pkg::CHAR_W-1:0]        char_q;
  logic                                last_q;
  logic [ritoa_pkg::COUNT_W-1:0]       total_q;
  logic                                err_q;

  logic                                div_done;
  logic [VW-1:0]                       quot;
  logic [ritoa_pkg::DIGIT_W-1:0]       rem;
  logic [ritoa_pkg::DIGIT_W-1:0]       rd_digit;

  logic [VW-1:0]                       in_val;
  logic                                in_neg;
  logic                                bad_base;
  logic [CW-1:0]                       rd_idx;
  logic [CW:0]                         total_sum;
  logic                                wr_en;

  // input decode
  always_comb begin
    in_val    = VW'(in_i.value);
    in_neg    = in_i.is_signed && in_val[VW-1];
    bad_base  = (in_i.base < ritoa_pkg::MIN_BASE) || (in_i.base > ritoa_pkg::MAX_BASE);
    rd_idx    = idx_q - CW'(1);
    total_sum = (CW+1)'(nd_q) + (CW+1)'(neg_q);
    wr_en     = (state_q == S_DIV_WAIT) && div_done;
  end

  // shared divider
  ritoa_div u_div (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (state_q == S_DIV_GO),
    .dividend_i  (mag_q),
    .divisor_i   (radix_q),
    .done_o      (div_done),
    .quotient_o  (quot),
    .remainder_o (rem)
  );

  // digit store, least significant digit at address zero
  ritoa_ram #(
    .WIDTH (ritoa_pkg::DIGIT_W),
    .DEPTH (ritoa_pkg::DIGIT_DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (wr_en),
    .waddr_i (nd_q[AW-1:0]),
    .wdata_i (rem),
    .raddr_i (rd_idx[AW-1:0]),
    .rdata_o (rd_digit)
  );

  // sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      neg_q   <= 1'b0;
      nd_q    <= '0;
      idx_q   <= '0;
      last_q  <= 1'b0;
      err_q   <= 1'b0;
      char_q  <= ritoa_pkg::NUL_CODE;
      total_q <= '0;
      mag_q   <= '0;
      radix_q <= '0;
    end else begin
      case (state_q)
        S_IDLE: begin
          if (in_i.valid) begin
            radix_q <= in_i.base;
            neg_q   <= in_neg;
            mag_q   <= in_neg ? (~in_val + VW'(1)) : in_val;
            nd_q    <= '0;
            if (bad_base) begin
              char_q  <= ritoa_pkg::NUL_CODE;
              last_q  <= 1'b1;
              total_q <= '0;
              err_q   <= 1'b1;
              state_q <= S_SHOW;
            end else begin
              state_q <= S_DIV_GO;
            end
          end
        end
        S_DIV_GO: begin
          state_q <= S_DIV_WAIT;
        end
        S_DIV_WAIT: begin
          if (div_done) begin
            mag_q <= quot;
            nd_q  <= nd_q + 1'b1;
            if ((quot == '0) || (nd_q == CW'(VW))) begin
              idx_q <= nd_q + 1'b1;
              if (neg_q) begin
                char_q  <= ritoa_pkg::MINUS_CODE;
                last_q  <= 1'b0;
                total_q <= '0;
                err_q   <= 1'b0;
                state_q <= S_SHOW;
              end else begin
                state_q <= S_RD;
              end
            end else begin
              state_q <= S_DIV_GO;
            end
          end
        end
        S_RD: begin
          state_q <= S_LOAD;
        end
        S_LOAD: begin
          idx_q   <= rd_idx;
          char_q  <= ritoa_pkg::digit_char(rd_digit);
          last_q  <= (idx_q == CW'(1));
          total_q <= (idx_q == CW'(1)) ? ritoa_pkg::COUNT_W'(total_sum) : '0;
          err_q   <= 1'b0;
          state_q <= S_SHOW;
        end
        S_SHOW: begin
          if (out_o.ready) begin
            state_q <= last_q ? S_IDLE : S_RD;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  // channel outputs
  assign in_i.ready        = (state_q == S_IDLE);
  assign out_o.valid       = (state_q == S_SHOW);
  assign out_o.char_code   = char_q;
  assign out_o.last        = last_q;
  assign out_o.total_chars = total_q;
  assign out_o.error       = err_q;

endmodule

`default_nettype wire

>>> hdl/ritoa_ram.sv
// generic simple dual port ram with registered read
`default_nettype none

module ritoa_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output      logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

>>> hdl/ritoa_div.sv
// restoring divider by a small radix, one quotient bit per cycle
`default_nettype none

module ritoa_div (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic                                start_i,
  input  wire logic [ritoa_pkg::VALUE_WIDTH-1:0]   dividend_i,
  input  wire logic [ritoa_pkg::BASE_W-1:0]        divisor_i,
  output      logic                                done_o,
  output      logic [ritoa_pkg::VALUE_WIDTH-1:0]   quotient_o,
  output      logic [ritoa_pkg::DIGIT_W-1:0]       remainder_o
);

  localparam int VW = ritoa_pkg::VALUE_WIDTH;
  localparam int DW = ritoa_pkg::DIGIT_W;

  logic                               busy_q;
  logic                               done_q;
  logic [ritoa_pkg::STEP_W-1:0]       step_q;
  logic [VW-1:0]                      dvd_q;
  logic [DW-1:0]                      rem_q;
  logic [ritoa_pkg::BASE_W-1:0]       dvs_q;

  logic [DW:0]                        trial;
  logic [DW:0]                        diff;
  logic                               fits;
  logic [DW-1:0]                      rem_d;

  // trial subtract of the shifted partial remainder
  always_comb begin
    trial = {rem_q, dvd_q[VW-1]};
    diff  = trial - (DW+1)'(dvs_q);
    fits  = trial >= (DW+1)'(dvs_q);
    rem_d = fits ? diff[DW-1:0] : trial[DW-1:0];
  end

  // control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else begin
      done_q <= busy_q && (step_q == '0);
      if (start_i) begin
        busy_q <= 1'b1;
        step_q <= ritoa_pkg::STEP_W'(VW - 1);
      end else if (busy_q) begin
        if (step_q == '0) begin
          busy_q <= 1'b0;
        end else begin
          step_q <= step_q - 1'b1;
        end
      end
    end
  end

  // datapath, quotient bits shift in where the dividend shifts out
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      dvd_q <= dividend_i;
      rem_q <= '0;
      dvs_q <= divisor_i;
    end else if (busy_q) begin
      dvd_q <= {dvd_q[VW-2:0], fits};
      rem_q <= rem_d;
    end
  end

  assign done_o      = done_q;
  assign quotient_o  = dvd_q;
  assign remainder_o = rem_q;

endmodule

`default_nettype wire

>>> hdl/ritoa_chk.sv
// port level checker for the converter, bound to the top level
`default_nettype none

module ritoa_chk (
  input wire logic                              clk_i,
  input wire logic                              rst_ni,
  input wire logic                              in_valid_i,
  input wire logic                              in_ready_i,
  input wire logic                              out_valid_i,
  input wire logic                              out_ready_i,
  input wire logic [ritoa_pkg::CHAR_W-1:0]      out_char_i,
  input wire logic                              out_last_i,
  input wire logic [ritoa_pkg::COUNT_W-1:0]     out_total_i,
  input wire logic                              out_error_i
);

  // one number at a time: no intake while a word is offered
  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(in_ready_i && out_valid_i))
    else $error("input ready while output word pending");

  // error word is a lone marked word without payload
  a_error_word: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && out_error_i) |->
      (out_last_i && (out_char_i == ritoa_pkg::NUL_CODE) && (out_total_i == '0)))
    else $error("malformed error word");

  // count only on the last word, errors only alone
  a_mid_word: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && !out_last_i) |-> ((out_total_i == '0) && !out_error_i))
    else $error("count or error on a non-final word");

  // after the last word the block returns to intake
  a_back_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && out_ready_i && out_last_i) |=> (!out_valid_i && in_ready_i))
    else $error("not idle after final word");

  // a taken number blocks further intake
  a_busy_after_take: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_i) |=> !in_ready_i)
    else $error("ready held after accepting a number");

endmodule

bind radix_integer_to_ascii_digits ritoa_chk u_ritoa_chk (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_i.valid),
  .in_ready_i  (in_i.ready),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .out_char_i  (out_o.char_code),
  .out_last_i  (out_o.last),
  .out_total_i (out_o.total_chars),
  .out_error_i (out_o.error)
);

`default_nettype wire

>>> verif/radix_integer_to_ascii_digits_test.sv
`timescale 1ns / 100ps
// self-checking testbench for the radix integer to ascii digit converter

module radix_integer_to_ascii_digits_test;

  localparam int CLK_PERIOD   = 12;
  localparam int RESET_CYCLES = 6;
  // the limit allows the slowest number plus a long stall on every word
  localparam int CYCLE_LIMIT  = 3_000_000;
  localparam int HOLD_CYCLES  = 400;
  localparam int DRAIN_CYCLES = 100;
  localparam int PRINT_CAP    = 60;

  typedef struct packed {
    logic [ritoa_pkg::CHAR_W-1:0]  char_code;
    logic                          last;
    logic [ritoa_pkg::COUNT_W-1:0] total_chars;
    logic                          error;
  } char_word_t;

  // how a directed row gets its expected words
  typedef enum logic [1:0] {
    BY_PREDICTOR,
    BY_TEXT,
    BY_ERROR
  } check_e;

  typedef struct {
    logic [ritoa_pkg::VALUE_IN_W-1:0] value;
    logic [ritoa_pkg::BASE_W-1:0]     base;
    logic                             sgn;
    check_e                           check;
    string                            text;
  } stim_row_t;

  // directed numbers: extremes, signed and unsigned, bad bases
  stim_row_t directed_rows[$] = '{
    '{32'd0,         6'd10, 1'b0, BY_TEXT,      "0"},
    '{32'd0,         6'd2,  1'b1, BY_TEXT,      "0"},
    '{32'hFFFF_FFFF, 6'd16, 1'b0, BY_TEXT,      "FFFFFFFF"},
    '{32'hFFFF_FFFF, 6'd10, 1'b0, BY_TEXT,      "4294967295"},
    '{32'hFFFF_FFFF, 6'd10, 1'b1, BY_TEXT,      "-1"},
    '{32'hFFFF_FFFF, 6'd36, 1'b0, BY_PREDICTOR, ""},
    '{32'hFFFF_FFFF, 6'd2,  1'b0, BY_PREDICTOR, ""},
    '{32'h8000_0000, 6'd10, 1'b1, BY_TEXT,      "-2147483648"},
    '{32'h8000_0000, 6'd16, 1'b1, BY_TEXT,      "-80000000"},
    '{32'h8000_0000, 6'd2,  1'b1, BY_PREDICTOR, ""},
    '{32'h8000_0000, 6'd10, 1'b0, BY_TEXT,      "2147483648"},
    '{32'h8000_0000, 6'd36, 1'b1, BY_PREDICTOR, ""},
    '{32'h7FFF_FFFF, 6'd10, 1'b1, BY_TEXT,      "2147483647"},
    '{32'h7FFF_FFFF, 6'd36, 1'b1, BY_PREDICTOR, ""},
    '{32'd35,        6'd36, 1'b0, BY_TEXT,      "Z"},
    '{32'd1,         6'd2,  1'b1, BY_TEXT,      "1"},
    '{32'd10,        6'd10, 1'b0, BY_TEXT,      "10"},
    '{32'd255,       6'd16, 1'b1, BY_TEXT,      "FF"},
    '{32'hFFFF_FFF6, 6'd3,  1'b1, BY_PREDICTOR, ""},
    '{32'd123456789, 6'd8,  1'b0, BY_PREDICTOR, ""},
    '{32'd5,         6'd37, 1'b0, BY_ERROR,     ""},
    '{32'hFFFF_FFFF, 6'd63, 1'b1, BY_ERROR,     ""},
    '{32'd7,         6'd0,  1'b0, BY_ERROR,     ""},
    '{32'd7,         6'd1,  1'b1, BY_ERROR,     ""}
  };

  logic clk_i;
  logic rst_ni;

  ritoa_in_if  number_ch ();
  ritoa_out_if char_ch ();

  radix_integer_to_ascii_digits uut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (number_ch),
    .out_o  (char_ch)
  );

  string      digit_set = "0123456789ABCDEFGHIJKLMNOPQRSTUVWXYZ";
  char_word_t pending_words[$];   // words of the number about to be offered
  char_word_t expected_chars[$];  // words of accepted numbers still to come out
  char_word_t oldest_word;

  int  send_idle_pct;
  int  recv_idle_pct;
  bit  hold_request;
  int  hold_left;
  int  cycle_count;
  int  mismatch_count;
  int  numbers_sent;
  int  bad_base_numbers;
  int  chars_checked;
  int  holds_done;

  // clock
  initial begin
    clk_i = 1'b0;
    forever #(CLK_PERIOD / 2) clk_i = ~clk_i;
  end

  // watchdog
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d words still expected",
               cycle_count, expected_chars.size());
      $display("RESULT: ERROR");
      $finish;
    end
  end

  task automatic note_mismatch(input string what);
    mismatch_count++;
    if (mismatch_count <= PRINT_CAP) begin
      $display("mismatch at cycle %0d: %s", cycle_count, what);
    end
  endtask

  function automatic void push_error_word();
    char_word_t w;
    w = '{char_code: ritoa_pkg::NUL_CODE, last: 1'b1, total_chars: '0, error: 1'b1};
    pending_words.push_back(w);
  endfunction

  // expected characters of one number, most significant digit first
  function automatic void predict_digits(input logic [ritoa_pkg::VALUE_IN_W-1:0] raw,
                                         input logic [ritoa_pkg::BASE_W-1:0] radix,
                                         input logic sgn);
    logic [ritoa_pkg::VALUE_WIDTH-1:0] mag;
    logic [ritoa_pkg::VALUE_WIDTH-1:0] wide_radix;
    logic                              neg;
    int                                rev[$];
    int                                total;
    char_word_t                        w;
    if (radix < ritoa_pkg::MIN_BASE || radix > ritoa_pkg::MAX_BASE) begin
      push_error_word();
      return;
    end
    mag        = raw[ritoa_pkg::VALUE_WIDTH-1:0];
    wide_radix = ritoa_pkg::VALUE_WIDTH'(radix);
    neg        = sgn && mag[ritoa_pkg::VALUE_WIDTH-1];
    // negating the most negative value wraps onto 2^(w-1), the right magnitude
    if (neg) begin
      mag = -mag;
    end
    do begin
      rev.push_back(int'(mag % wide_radix));
      mag = mag / wide_radix;
    end while (mag != '0);
    total = rev.size() + (neg ? 1 : 0);
    if (neg) begin
      w = '{char_code: ritoa_pkg::MINUS_CODE, last: 1'b0, total_chars: '0, error: 1'b0};
      pending_words.push_back(w);
    end
    for (int k = rev.size() - 1; k >= 0; k--) begin
      w.char_code   = ritoa_pkg::CHAR_W'(digit_set[rev[k]]);
      w.last        = (k == 0);
      w.total_chars = (k == 0) ? ritoa_pkg::COUNT_W'(total) : '0;
      w.error       = 1'b0;
      pending_words.push_back(w);
    end
  endfunction

  // offer one number; its expected words are queued once it is taken
  task automatic send_number(input logic [ritoa_pkg::VALUE_IN_W-1:0] v,
                             input logic [ritoa_pkg::BASE_W-1:0] b,
                             input logic s);
    int gap;
    gap = ($urandom_range(99) < send_idle_pct / 4) ? $urandom_range(1, 1200) : 0;
    while (gap > 0 || $urandom_range(99) < send_idle_pct) begin
      number_ch.valid <= 1'b0;
      if (gap > 0) begin
        gap--;
      end
      @(negedge clk_i);
    end
    number_ch.valid     <= 1'b1;
    number_ch.value     <= v;
    number_ch.base      <= b;
    number_ch.is_signed <= s;
    do @(posedge clk_i); while (number_ch.ready !== 1'b1);
    foreach (pending_words[k]) begin
      expected_chars.push_back(pending_words[k]);
    end
    if (pending_words[0].error) begin
      bad_base_numbers++;
    end
    numbers_sent++;
    pending_words.delete();
    @(negedge clk_i);
  endtask

  // sender stays quiet until every expected word has come out
  task automatic wait_for_drain();
    number_ch.valid <= 1'b0;
    while (expected_chars.size() != 0) begin
      @(negedge clk_i);
    end
  endtask

  task automatic run_random_phase(input int count, input int send_pct,
                                  input int recv_pct, input int hold_at);
    logic [ritoa_pkg::VALUE_IN_W-1:0] v;
    logic [ritoa_pkg::BASE_W-1:0]     b;
    logic                             s;
    int                               r;
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
    for (int n = 0; n < count; n++) begin
      if (n == hold_at) begin
        hold_request = 1'b1;
        holds_done++;
      end
      // value: mostly full range, some small, some around the sign boundary
      case ($urandom_range(9))
        0, 1, 2, 3, 4: v = $urandom;
        5, 6:          v = 32'($urandom_range(0, 40));
        7:             v = 32'h7FFF_FFFE + 32'($urandom_range(0, 3));
        8:             v = 32'hFFFF_FFFF - 32'($urandom_range(0, 3));
        default:       v = 32'($urandom_range(0, 65535));
      endcase
      // base: few slow small bases, some bad ones
      r = $urandom_range(99);
      if (r < 8) begin
        b = ritoa_pkg::BASE_W'($urandom_range(37, 63));
      end else if (r < 11) begin
        b = ritoa_pkg::BASE_W'($urandom_range(0, 1));
      end else if (r < 20) begin
        b = ritoa_pkg::BASE_W'($urandom_range(2, 4));
      end else begin
        b = ritoa_pkg::BASE_W'($urandom_range(5, 36));
      end
      s = 1'($urandom_range(1));
      predict_digits(v, b, s);
      send_number(v, b, s);
    end
    wait_for_drain();
  endtask

  // receiver: random stalls, plus a long hold-off on request
  initial begin
    char_ch.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_request) begin
        hold_left    = HOLD_CYCLES;
        hold_request = 1'b0;
      end
      if (hold_left > 0) begin
        hold_left--;
        char_ch.ready <= 1'b0;
      end else begin
        char_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  // output checker
  always @(posedge clk_i) begin
    if (rst_ni && char_ch.valid === 1'b1 && char_ch.ready === 1'b1) begin
      chars_checked++;
      if (expected_chars.size() == 0) begin
        note_mismatch($sformatf("word with nothing expected: char %h last %b count %0d err %b",
                                char_ch.char_code, char_ch.last, char_ch.total_chars,
                                char_ch.error));
      end else begin
        oldest_word = expected_chars.pop_front();
        if (char_ch.char_code !== oldest_word.char_code ||
            char_ch.last !== oldest_word.last ||
            char_ch.total_chars !== oldest_word.total_chars ||
            char_ch.error !== oldest_word.error) begin
          note_mismatch($sformatf(
            "got char %h last %b count %0d err %b, want char %h last %b count %0d err %b",
            char_ch.char_code, char_ch.last, char_ch.total_chars, char_ch.error,
            oldest_word.char_code, oldest_word.last, oldest_word.total_chars,
            oldest_word.error));
        end
      end
    end
  end

  // main sequence
  initial begin
    string      txt;
    char_word_t w;
    rst_ni              = 1'b0;
    number_ch.valid     = 1'b0;
    number_ch.value     = '0;
    number_ch.base      = '0;
    number_ch.is_signed = 1'b0;
    send_idle_pct       = 21;
    recv_idle_pct       = 51;
    repeat (RESET_CYCLES) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // directed table
    foreach (directed_rows[r]) begin
      case (directed_rows[r].check)
        BY_TEXT: begin
          txt = directed_rows[r].text;
          for (int k = 0; k < txt.len(); k++) begin
            w.char_code   = ritoa_pkg::CHAR_W'(txt[k]);
            w.last        = (k == txt.len() - 1);
            w.total_chars = w.last ? ritoa_pkg::COUNT_W'(txt.len()) : '0;
            w.error       = 1'b0;
            pending_words.push_back(w);
          end
        end
        BY_ERROR: push_error_word();
        default: predict_digits(directed_rows[r].value, directed_rows[r].base,
                                directed_rows[r].sgn);
      endcase
      send_number(directed_rows[r].value, directed_rows[r].base, directed_rows[r].sgn);
    end
    wait_for_drain();

    // random phases: slow receiver, slow sender, then full speed
    run_random_phase(70, 21, 51, 30);
    run_random_phase(65, 51, 21, -1);
    run_random_phase(65, 0, 0, 20);

    repeat (DRAIN_CYCLES) @(negedge clk_i);
    if (expected_chars.size() != 0) begin
      note_mismatch($sformatf("%0d expected words never came out", expected_chars.size()));
    end

    $display("converted %0d numbers (%0d directed, %0d with a bad base), %0d words checked",
             numbers_sent, directed_rows.size(), bad_base_numbers, chars_checked);
    $display("idle mixes 21/51, 51/21 and none; %0d receiver hold-offs of %0d cycles",
             holds_done, HOLD_CYCLES);
    if (mismatch_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
